FILE: rtl/gnss_binary_packet_deframer_assert.svh
`ifndef GNSS_BINARY_PACKET_DEFRAMER_ASSERT_SVH
`define GNSS_BINARY_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define GBPD_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define GBPD_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: rtl/gbpd_pkg.sv
package gbpd_pkg;

   localparam logic [7:0] SYNC_WORD [4] = '{8'h50, 8'h53, 8'h47, 8'h47};

   // xor lanes after folding the sync word into lanes 0 to 3
   localparam logic [31:0] SYNC_XOR_SEED = {SYNC_WORD[3], SYNC_WORD[2], SYNC_WORD[1],
                                            SYNC_WORD[0]};

   localparam logic [15:0] ID_GEODATA = 16'h0020;
   localparam logic [15:0] ID_TELEM   = 16'h0021;
   localparam logic [15:0] ID_SATS    = 16'h0022;

   localparam logic [1:0] ROUTE_GEODATA = 2'd0;
   localparam logic [1:0] ROUTE_TELEM   = 2'd1;
   localparam logic [1:0] ROUTE_SATS    = 2'd2;
   localparam logic [1:0] ROUTE_DROP    = 2'd3;

   localparam logic [1:0]  LAST_LANE     = 2'd3;
   localparam logic [16:0] MAX_WORDS     = 17'h10000;

endpackage

FILE: rtl/gnss_binary_packet_deframer.sv
// gnss_binary_packet_deframer
// takes one received byte per req transaction (req_rx_byte) and hunts for the
// sync word "PSGG", then reads a little-endian 16-bit packet id and word count,
// streams the payload as one rsp transaction per byte with its offset, checks
// four trailing checksum bytes and closes the packet with one verdict
// transaction (rsp_end_of_packet high, rsp_checksum_ok, rsp_route).
// header, sync and checksum bytes other than the last give no rsp transaction.
// a payload byte is first held in the input register, then decoded into the
// output register, which drives the rsp outputs.
// throughput: one byte per cycle unless the receiver stalls, set by the
// input register and the output register.
// when the receiver stalls, the output register holds its transaction and one
// more byte is taken into the input register; req_stall then rises until the
// output drains.
// reset (synchronous, active high) empties both registers and returns to the
// sync hunt with all counters and checksum lanes cleared.
module gnss_binary_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_packet_id,
   output logic [17:0] rsp_byte_offset,
   output logic        rsp_end_of_packet,
   output logic        rsp_checksum_ok,
   output logic [1:0]  rsp_route
);
   import gbpd_pkg::*;

   `include "gnss_binary_packet_deframer_assert.svh"

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_ID_LO = 4'd1,
      PH_ID_HI = 4'd2,
      PH_SZ_LO = 4'd3,
      PH_SZ_HI = 4'd4,
      PH_DATA  = 4'd5,
      PH_CHECK = 4'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  sync_cnt_ff, sync_cnt_in;
   logic [15:0] cur_id_ff, cur_id_in;
   logic [16:0] words_left_ff, words_left_in;
   logic [1:0]  byte_in_word_ff, byte_in_word_in;
   logic [17:0] payload_cnt_ff, payload_cnt_in;
   logic [31:0] xor_ff, xor_in;
   logic [1:0]  lane_ptr_ff, lane_ptr_in;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [17:0] rsp_offset_ff, rsp_offset_in;
   logic        rsp_eop_ff, rsp_eop_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [1:0]  rsp_route_ff, rsp_route_in;

   logic        req_accept;
   logic        advance;
   logic        emit;
   logic [31:0] xor_fold;
   logic [16:0] words_dec;
   logic [16:0] words_size;
   logic [1:0]  route_sel;

   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign xor_fold   = xor_ff ^ ({24'b0, in_byte_ff} << {lane_ptr_ff, 3'b000});
   assign words_dec  = words_left_ff - 17'd1;
   assign words_size = {1'b0, in_byte_ff, words_left_ff[7:0]};

   always_comb begin
      priority if (cur_id_ff == ID_GEODATA) begin
         route_sel = ROUTE_GEODATA;
      end else if (cur_id_ff == ID_TELEM) begin
         route_sel = ROUTE_TELEM;
      end else if (cur_id_ff == ID_SATS) begin
         route_sel = ROUTE_SATS;
      end else begin
         route_sel = ROUTE_DROP;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      sync_cnt_in     = sync_cnt_ff;
      cur_id_in       = cur_id_ff;
      words_left_in   = words_left_ff;
      byte_in_word_in = byte_in_word_ff;
      payload_cnt_in  = payload_cnt_ff;
      xor_in          = xor_ff;
      lane_ptr_in     = lane_ptr_ff;
      emit            = 1'b0;
      rsp_data_in     = rsp_data_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_eop_in      = rsp_eop_ff;
      rsp_ok_in       = rsp_ok_ff;
      rsp_route_in    = rsp_route_ff;

      if (advance) begin
         if (phase_ff != PH_HUNT) begin
            xor_in      = xor_fold;
            lane_ptr_in = lane_ptr_ff + 2'd1;
         end
         unique case (phase_ff)
            PH_ID_LO: begin
               cur_id_in = {8'b0, in_byte_ff};
               phase_in  = PH_ID_HI;
            end
            PH_ID_HI: begin
               cur_id_in = {in_byte_ff, cur_id_ff[7:0]};
               phase_in  = PH_SZ_LO;
            end
            PH_SZ_LO: begin
               words_left_in = {9'b0, in_byte_ff};
               phase_in      = PH_SZ_HI;
            end
            PH_SZ_HI: begin
               words_left_in   = (words_size == 17'd0) ? MAX_WORDS : words_size;
               byte_in_word_in = 2'd0;
               payload_cnt_in  = 18'd0;
               phase_in        = PH_DATA;
            end
            PH_DATA: begin
               emit           = 1'b1;
               rsp_data_in    = in_byte_ff;
               rsp_id_in      = cur_id_ff;
               rsp_offset_in  = payload_cnt_ff;
               rsp_eop_in     = 1'b0;
               rsp_ok_in      = 1'b0;
               rsp_route_in   = ROUTE_GEODATA;
               payload_cnt_in = payload_cnt_ff + 18'd1;
               if (byte_in_word_ff == LAST_LANE) begin
                  byte_in_word_in = 2'd0;
                  words_left_in   = words_dec;
                  if (words_dec == 17'd0) begin
                     phase_in = PH_CHECK;
                  end
               end else begin
                  byte_in_word_in = byte_in_word_ff + 2'd1;
               end
            end
            PH_CHECK: begin
               if (byte_in_word_ff != LAST_LANE) begin
                  byte_in_word_in = byte_in_word_ff + 2'd1;
               end else begin
                  emit            = 1'b1;
                  rsp_data_in     = 8'd0;
                  rsp_id_in       = cur_id_ff;
                  rsp_offset_in   = 18'd0;
                  rsp_eop_in      = 1'b1;
                  rsp_ok_in       = (xor_fold == 32'd0);
                  rsp_route_in    = route_sel;
                  byte_in_word_in = 2'd0;
                  payload_cnt_in  = 18'd0;
                  phase_in        = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (in_byte_ff == SYNC_WORD[sync_cnt_ff]) begin
                  if (sync_cnt_ff == LAST_LANE) begin
                     sync_cnt_in = 2'd0;
                     xor_in      = SYNC_XOR_SEED;
                     lane_ptr_in = 2'd0;
                     phase_in    = PH_ID_LO;
                  end else begin
                     sync_cnt_in = sync_cnt_ff + 2'd1;
                  end
               end else begin
                  sync_cnt_in = 2'd0;
               end
            end
         endcase
      end

      in_byte_in  = req_accept ? req_rx_byte : in_byte_ff;
      in_valid_in = req_accept || (in_valid_ff && !advance);
      rsp_valid_in = advance ? emit : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         sync_cnt_ff     <= 2'd0;
         cur_id_ff       <= 16'd0;
         words_left_ff   <= 17'd0;
         byte_in_word_ff <= 2'd0;
         payload_cnt_ff  <= 18'd0;
         xor_ff          <= 32'd0;
         lane_ptr_ff     <= 2'd0;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         sync_cnt_ff     <= sync_cnt_in;
         cur_id_ff       <= cur_id_in;
         words_left_ff   <= words_left_in;
         byte_in_word_ff <= byte_in_word_in;
         payload_cnt_ff  <= payload_cnt_in;
         xor_ff          <= xor_in;
         lane_ptr_ff     <= lane_ptr_in;
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_eop_ff    <= rsp_eop_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_route_ff  <= rsp_route_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_data_ff;
   assign rsp_packet_id     = rsp_id_ff;
   assign rsp_byte_offset   = rsp_offset_ff;
   assign rsp_end_of_packet = rsp_eop_ff;
   assign rsp_checksum_ok   = rsp_ok_ff;
   assign rsp_route         = rsp_route_ff;

   `GBPD_ASSERT_IMPLY(a_verdict_zero_payload, clock, reset,
      rsp_valid_ff && rsp_eop_ff, rsp_data_ff == 8'd0 && rsp_offset_ff == 18'd0,
      "verdict transaction carries payload data")
   `GBPD_ASSERT_IMPLY(a_payload_no_verdict, clock, reset,
      rsp_valid_ff && !rsp_eop_ff, !rsp_ok_ff && rsp_route_ff == ROUTE_GEODATA,
      "payload transaction carries verdict fields")
   `GBPD_ASSERT_IMPLY(a_data_words_left, clock, reset,
      phase_ff == PH_DATA, words_left_ff != 17'd0,
      "payload phase with no words left")
   `GBPD_ASSERT_NEXT(a_verdict_to_hunt, clock, reset,
      advance && phase_ff == PH_CHECK && byte_in_word_ff == LAST_LANE,
      phase_ff == PH_HUNT && rsp_valid_ff && rsp_eop_ff,
      "last checksum byte did not close the packet")

endmodule
